// ===== rtl/bpm_pkg.sv =====
`timescale 1ns / 1ps

package bpm_pkg;

  // boot stage codes, T0..T7 plus invalid
  typedef enum logic [3:0] {
    ST_T0  = 4'd0,
    ST_T1  = 4'd1,
    ST_T2  = 4'd2,
    ST_T3  = 4'd3,
    ST_T4  = 4'd4,
    ST_T5  = 4'd5,
    ST_T6  = 4'd6,
    ST_T7  = 4'd7,
    ST_BAD = 4'd8
  } stage_e;

  // event kinds carried by an input item
  typedef enum logic [1:0] {
    OP_RESET_PIN = 2'd0,
    OP_BOOT_PIN  = 2'd1,
    OP_TICK      = 2'd2
  } op_e;

  // configuration register indexes (word address bits)
  localparam logic [1:0] REG_EARLY_LIMIT  = 2'd0;
  localparam logic [1:0] REG_LOADER_LIMIT = 2'd1;
  localparam logic [1:0] REG_LATE_LIMIT   = 2'd2;

  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned ADDR_W  = 4;

  // reset values of the limit registers
  localparam logic [LIMIT_W-1:0] EARLY_LIMIT_RST  = 16'd500;
  localparam logic [LIMIT_W-1:0] LOADER_LIMIT_RST = 16'd1000;
  localparam logic [LIMIT_W-1:0] LATE_LIMIT_RST   = 16'd10000;

endpackage

// ===== rtl/boot_progress_monitor_unit.sv =====
`timescale 1ns / 1ps

// Boot progress monitor. Each input item is one event (reset pin change, boot
// pin change or timer tick) and yields exactly one result item with the current
// boot stage, the sticky boot-done flag, a timeout flag and the counter state.
// The update is combinational logic between the state and result registers, so
// one item is taken per clock; the result register frees itself in the same
// cycle its item is taken, so the input stalls only while a result waits and
// the output side stalls. Stage tick limits must be written through the APB
// port at byte addresses 0, 4 and 8 only while no item is in flight; the block
// does not enforce this. The tick counter is TICK_BITS wide and saturates.
module boot_progress_monitor_unit #(
  parameter int unsigned TICK_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic        reset_pin_high_i,
  input  logic        power_good_i,
  input  logic        alert_one_i,
  input  logic        alert_two_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  boot_stage_o,
  output logic        boot_done_o,
  output logic        timed_out_o,
  output logic        timer_running_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned CMP_W = (TICK_BITS > bpm_pkg::LIMIT_W) ? TICK_BITS : bpm_pkg::LIMIT_W;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  // limit registers
  logic [bpm_pkg::LIMIT_W-1:0] early_limit_q, loader_limit_q, late_limit_q;

  // monitor state
  bpm_pkg::stage_e             stage_q, stage_d;
  bpm_pkg::stage_e             last_stage_q, last_stage_d;
  logic                        second_pass_q, second_pass_d;
  logic [TICK_BITS-1:0]        elapsed_q, elapsed_d;
  logic [bpm_pkg::LIMIT_W-1:0] active_limit_q, active_limit_d;
  logic                        counting_q, counting_d;
  logic                        done_q, done_d;
  logic                        timeout_d;

  // result register
  logic       out_valid_q;
  logic [3:0] res_stage_q;
  logic       res_done_q, res_timeout_q, res_running_q;

  logic accept;
  logic cfg_wr;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // apb register access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_limit_q  <= bpm_pkg::EARLY_LIMIT_RST;
      loader_limit_q <= bpm_pkg::LOADER_LIMIT_RST;
      late_limit_q   <= bpm_pkg::LATE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bpm_pkg::REG_EARLY_LIMIT:  early_limit_q  <= pwdata[bpm_pkg::LIMIT_W-1:0];
        bpm_pkg::REG_LOADER_LIMIT: loader_limit_q <= pwdata[bpm_pkg::LIMIT_W-1:0];
        bpm_pkg::REG_LATE_LIMIT:   late_limit_q   <= pwdata[bpm_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bpm_pkg::REG_EARLY_LIMIT:  prdata = {{(32-bpm_pkg::LIMIT_W){1'b0}}, early_limit_q};
      bpm_pkg::REG_LOADER_LIMIT: prdata = {{(32-bpm_pkg::LIMIT_W){1'b0}}, loader_limit_q};
      bpm_pkg::REG_LATE_LIMIT:   prdata = {{(32-bpm_pkg::LIMIT_W){1'b0}}, late_limit_q};
      default:                   prdata = '0;
    endcase
  end

  // event processing: pin decode, stage entry and tick counting
  always_comb begin
    bpm_pkg::stage_e             new_stage;
    logic                        enter;
    logic [CMP_W-1:0]            elapsed_ext;
    logic [CMP_W-1:0]            limit_ext;

    new_stage      = stage_q;
    enter          = 1'b0;
    elapsed_ext    = CMP_W'(elapsed_q);
    limit_ext      = CMP_W'(active_limit_q);

    stage_d        = stage_q;
    last_stage_d   = last_stage_q;
    second_pass_d  = second_pass_q;
    elapsed_d      = elapsed_q;
    active_limit_d = active_limit_q;
    counting_d     = counting_q;
    done_d         = done_q;
    timeout_d      = 1'b0;

    if (accept) begin
      case (opcode_i)
        bpm_pkg::OP_RESET_PIN: begin
          second_pass_d = 1'b0;
          if (reset_pin_high_i) begin
            new_stage = bpm_pkg::ST_T0;
            enter     = 1'b1;
          end else if (power_good_i) begin
            new_stage = bpm_pkg::ST_T0;
          end else begin
            new_stage = bpm_pkg::ST_BAD;
          end
          stage_d      = new_stage;
          last_stage_d = new_stage;
        end
        bpm_pkg::OP_BOOT_PIN: begin
          // two-pass decode of the alert pins
          if (!second_pass_q) begin
            if (!alert_two_i) begin
              new_stage = alert_one_i ? bpm_pkg::ST_T2 : bpm_pkg::ST_T1;
            end else if (alert_one_i) begin
              new_stage = bpm_pkg::ST_T3;
            end else begin
              new_stage     = bpm_pkg::ST_T4;
              second_pass_d = 1'b1;
            end
          end else begin
            if (!alert_two_i) begin
              new_stage = alert_one_i ? bpm_pkg::ST_T6 : bpm_pkg::ST_T5;
            end else if (alert_one_i) begin
              new_stage     = bpm_pkg::ST_T7;
              second_pass_d = 1'b0;
            end else begin
              new_stage = bpm_pkg::ST_BAD;
            end
          end
          stage_d      = new_stage;
          last_stage_d = new_stage;
          enter        = 1'b1;
        end
        bpm_pkg::OP_TICK: begin
          if (counting_q && stage_q != bpm_pkg::ST_T7) begin
            if (stage_q == last_stage_q) begin
              if (elapsed_q != TICK_MAX) begin
                elapsed_d = elapsed_q + 1'b1;
              end
              if (elapsed_ext > limit_ext) begin
                counting_d = 1'b0;
                timeout_d  = 1'b1;
              end
            end else if (stage_q > last_stage_q) begin
              last_stage_d = stage_q;
              counting_d   = 1'b0;
            end
          end
        end
        default: ;
      endcase

      // entering T0..T6 restarts the counter with that stage's limit; T7 sets done
      if (enter) begin
        case (new_stage)
          bpm_pkg::ST_T0, bpm_pkg::ST_T1, bpm_pkg::ST_T2, bpm_pkg::ST_T3: begin
            active_limit_d = early_limit_q;
            elapsed_d      = '0;
            counting_d     = 1'b1;
          end
          bpm_pkg::ST_T4: begin
            active_limit_d = loader_limit_q;
            elapsed_d      = '0;
            counting_d     = 1'b1;
          end
          bpm_pkg::ST_T5, bpm_pkg::ST_T6: begin
            active_limit_d = late_limit_q;
            elapsed_d      = '0;
            counting_d     = 1'b1;
          end
          bpm_pkg::ST_T7: done_d = 1'b1;
          default: ;
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q        <= bpm_pkg::ST_BAD;
      last_stage_q   <= bpm_pkg::ST_BAD;
      second_pass_q  <= 1'b0;
      elapsed_q      <= '0;
      active_limit_q <= bpm_pkg::LATE_LIMIT_RST;
      counting_q     <= 1'b0;
      done_q         <= 1'b0;
    end else begin
      stage_q        <= stage_d;
      last_stage_q   <= last_stage_d;
      second_pass_q  <= second_pass_d;
      elapsed_q      <= elapsed_d;
      active_limit_q <= active_limit_d;
      counting_q     <= counting_d;
      done_q         <= done_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      res_stage_q   <= bpm_pkg::ST_BAD;
      res_done_q    <= 1'b0;
      res_timeout_q <= 1'b0;
      res_running_q <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_q   <= 1'b1;
        res_stage_q   <= stage_d;
        res_done_q    <= done_d;
        res_timeout_q <= timeout_d;
        res_running_q <= counting_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign boot_stage_o    = res_stage_q;
  assign boot_done_o     = res_done_q;
  assign timed_out_o     = res_timeout_q;
  assign timer_running_o = res_running_q;

endmodule

// ===== rtl/bpm_checker.sv =====
`timescale 1ns / 1ps

module bpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  boot_stage_o,
  input logic        boot_done_o,
  input logic        timed_out_o,
  input logic        timer_running_o
);

  // boot done never falls back once shown
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(boot_done_o) |-> boot_done_o)
    else $error("boot_done_o dropped");

  // a timeout always stops the counter
  a_timeout_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && timed_out_o) |-> !timer_running_o)
    else $error("timeout with timer still running");

  // no timeout is reported in the final stage
  a_no_timeout_t7: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && timed_out_o) |-> (boot_stage_o != bpm_pkg::ST_T7))
    else $error("timeout reported in stage T7");

  // reaching T7 implies boot done
  a_t7_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && boot_stage_o == bpm_pkg::ST_T7) |-> boot_done_o)
    else $error("stage T7 without boot done");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(boot_stage_o)
      && $stable(timed_out_o) && $stable(timer_running_o)))
    else $error("stalled item changed");

endmodule

bind boot_progress_monitor_unit bpm_checker u_bpm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .boot_stage_o    (boot_stage_o),
  .boot_done_o     (boot_done_o),
  .timed_out_o     (timed_out_o),
  .timer_running_o (timer_running_o)
);
